FILE: rtl/core/epsc_pkg.sv
// shared types, constants and the month table for the epoch-to-calendar pipeline
// no dependencies; imported by epsc_date_walk and epoch_seconds_to_calendar
`default_nettype none

package epsc_pkg;

   // seconds from 1970-01-01 to 2000-01-01, and the last second of 2099
   localparam logic [31:0] EPOCH_2000_SECONDS = 32'd946684800;
   localparam logic [31:0] LAST_VALID_SECONDS = 32'd4102444799;

   // reciprocal constants: x/15 = (x*DIV15_MAGIC) >> 35, x/3 = (x*DIV3_MAGIC) >> 33
   localparam logic [31:0] DIV15_MAGIC = 32'h88888889;
   localparam logic [31:0] DIV3_MAGIC  = 32'hAAAAAAAB;
   // x/1461 = (x*DIV1461_MAGIC) >> 32, exact for any 16-bit day count
   localparam logic [21:0] DIV1461_MAGIC = 22'd2939745;
   localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;

   // first day of each year within a four-year group
   localparam logic [10:0] YEAR1_START = 11'd366;
   localparam logic [10:0] YEAR2_START = 11'd731;
   localparam logic [10:0] YEAR3_START = 11'd1096;

   // time of day carried alongside the date stages
   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } epsc_tod_type;

   // one finished result beat
   typedef struct packed {
      logic [6:0]   year;
      logic [3:0]   month;
      logic [4:0]   day;
      epsc_tod_type tod;
      logic         in_range;
   } epsc_result_type;

   // zero-based day of year on which a month starts
   function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
      logic [8:0] base;
      case (month)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (month >= 4'd3)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/epsc_date_walk.sv
// date stages: day count to year, month and day of month, five register stages
// depends on epsc_pkg for the month table, reciprocal constant and result types
`default_nettype none

module epsc_date_walk (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     day_valid,
   input  wire logic [15:0]              day_count,
   input  wire logic                     day_in_range,
   input  wire epsc_pkg::epsc_tod_type   day_tod,
   output      logic                     result_valid,
   output      epsc_pkg::epsc_result_type result
);
   import epsc_pkg::*;

   // stage 5: four-year group by reciprocal multiply
   logic [37:0]  quad_prod;
   logic [5:0]   quad_in;
   logic         s5_valid_ff;
   logic         s5_range_ff;
   logic [15:0]  s5_days_ff;
   logic [5:0]   s5_quad_ff;
   epsc_tod_type s5_tod_ff;

   assign quad_prod = 38'(day_count) * 38'(DIV1461_MAGIC);
   assign quad_in   = quad_prod[37:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= day_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_range_ff <= day_in_range;
         s5_days_ff  <= day_count;
         s5_quad_ff  <= quad_in;
         s5_tod_ff   <= day_tod;
      end
   end

   // stage 6: day within the four-year group
   logic [15:0]  quad_days;
   logic [15:0]  rem_full;
   logic [10:0]  rem_in;
   logic         s6_valid_ff;
   logic         s6_range_ff;
   logic [10:0]  s6_rem_ff;
   logic [5:0]   s6_quad_ff;
   epsc_tod_type s6_tod_ff;

   assign quad_days = 16'(s5_quad_ff) * 16'(DAYS_PER_QUAD);
   assign rem_full  = s5_days_ff - quad_days;
   assign rem_in    = rem_full[10:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_range_ff <= s5_range_ff;
         s6_rem_ff   <= rem_in;
         s6_quad_ff  <= s5_quad_ff;
         s6_tod_ff   <= s5_tod_ff;
      end
   end

   // stage 7: year within the group, first year of each group is leap
   logic [1:0]   year_sel;
   logic [10:0]  doy_full;
   logic [6:0]   year_in;
   logic         s7_valid_ff;
   logic         s7_range_ff;
   logic [6:0]   s7_year_ff;
   logic [8:0]   s7_doy_ff;
   logic         s7_leap_ff;
   epsc_tod_type s7_tod_ff;

   always_comb begin
      if (s6_rem_ff < YEAR1_START) begin
         year_sel = 2'd0;
         doy_full = s6_rem_ff;
      end else if (s6_rem_ff < YEAR2_START) begin
         year_sel = 2'd1;
         doy_full = s6_rem_ff - YEAR1_START;
      end else if (s6_rem_ff < YEAR3_START) begin
         year_sel = 2'd2;
         doy_full = s6_rem_ff - YEAR2_START;
      end else begin
         year_sel = 2'd3;
         doy_full = s6_rem_ff - YEAR3_START;
      end
   end

   assign year_in = {s6_quad_ff[4:0], year_sel};

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_range_ff <= s6_range_ff;
         s7_year_ff  <= year_in;
         s7_doy_ff   <= doy_full[8:0];
         s7_leap_ff  <= (year_sel == 2'd0);
         s7_tod_ff   <= s6_tod_ff;
      end
   end

   // stage 8: month from compares against every month start
   logic [3:0]   month_in;
   logic         s8_valid_ff;
   logic         s8_range_ff;
   logic [6:0]   s8_year_ff;
   logic [8:0]   s8_doy_ff;
   logic         s8_leap_ff;
   logic [3:0]   s8_month_ff;
   epsc_tod_type s8_tod_ff;

   always_comb begin
      month_in = 4'd1;
      for (int m = 2; m <= 12; m++) begin
         if (s7_doy_ff >= month_start(4'(m), s7_leap_ff)) begin
            month_in = month_in + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (advance) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s8_range_ff <= s7_range_ff;
         s8_year_ff  <= s7_year_ff;
         s8_doy_ff   <= s7_doy_ff;
         s8_leap_ff  <= s7_leap_ff;
         s8_month_ff <= month_in;
         s8_tod_ff   <= s7_tod_ff;
      end
   end

   // stage 9: day of month, out-of-range beats forced to zero
   logic [8:0]      day_full;
   epsc_result_type result_in;
   logic            s9_valid_ff;
   epsc_result_type s9_result_ff;

   assign day_full = s8_doy_ff - month_start(s8_month_ff, s8_leap_ff) + 9'd1;

   always_comb begin
      if (s8_range_ff) begin
         result_in.year     = s8_year_ff;
         result_in.month    = s8_month_ff;
         result_in.day      = day_full[4:0];
         result_in.tod      = s8_tod_ff;
         result_in.in_range = 1'b1;
      end else begin
         result_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else if (advance) begin
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s9_result_ff <= result_in;
      end
   end

   assign result_valid = s9_valid_ff;
   assign result       = s9_result_ff;

endmodule

`default_nettype wire

FILE: rtl/core/epoch_seconds_to_calendar.sv
// top level: Unix seconds to calendar date and time of day, years 2000 to 2099
// depends on epsc_pkg and epsc_date_walk
//
// Usage:
//   req channel carries one 32-bit count of seconds since 1970-01-01 per beat;
//   a beat is taken at a clock edge with req_valid high and req_stall low.
//   rsp channel returns exactly one result beat per request beat, in order:
//   year since 2000, month, day, hour, minute, second and in_range. Outside
//   2000-01-01 through 2099-12-31 in_range is low and all other fields are zero.
//   Nine register stages carry a beat from the request to the result. The
//   stages are: range check and offset, three reciprocal divides (60, 60, 24), the
//   four-year group divide, group remainder, year select, month compare and
//   day of month. One beat per cycle is sustained while rsp_stall is low.
//   While the output holds a beat and rsp_stall is high, the whole pipeline
//   freezes and req_stall goes high; nothing is dropped or repeated.
//   Reset (synchronous, active high) empties the pipeline.
`default_nettype none

module epoch_seconds_to_calendar (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [31:0] req_unix_seconds,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [6:0]  rsp_year_offset,
   output      logic [3:0]  rsp_month_number,
   output      logic [4:0]  rsp_day_of_month,
   output      logic [4:0]  rsp_hour_of_day,
   output      logic [5:0]  rsp_minute_of_hour,
   output      logic [5:0]  rsp_second_of_minute,
   output      logic        rsp_in_range
);
   import epsc_pkg::*;

   // whole pipeline moves unless a finished beat is held by the receiver
   logic            advance;
   logic            out_valid;
   epsc_result_type out_result;

   assign advance   = !(out_valid && rsp_stall);
   assign req_stall = !advance;

   // stage 1: range check and shift to the 2000 epoch
   logic        range_in;
   logic [31:0] secs_in;
   logic        s1_valid_ff;
   logic        s1_range_ff;
   logic [31:0] s1_secs_ff;

   assign range_in = (req_unix_seconds >= EPOCH_2000_SECONDS) &&
                     (req_unix_seconds <= LAST_VALID_SECONDS);
   assign secs_in  = req_unix_seconds - EPOCH_2000_SECONDS;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_range_ff <= range_in;
         s1_secs_ff  <= secs_in;
      end
   end

   // stage 2: total minutes = secs/60 = (secs>>2)/15
   logic [63:0] min_prod;
   logic [26:0] mins_in;
   logic        s2_valid_ff;
   logic        s2_range_ff;
   logic [26:0] s2_mins_ff;
   logic [5:0]  s2_secs_lo_ff;

   assign min_prod = 64'(s1_secs_ff[31:2]) * 64'(DIV15_MAGIC);
   assign mins_in  = min_prod[61:35];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_range_ff   <= s1_range_ff;
         s2_mins_ff    <= mins_in;
         s2_secs_lo_ff <= s1_secs_ff[5:0];
      end
   end

   // stage 3: total hours = mins/60, seconds = secs - 60*mins taken mod 64
   logic [63:0] hour_prod;
   logic [20:0] hours_in;
   logic [5:0]  second_in;
   logic        s3_valid_ff;
   logic        s3_range_ff;
   logic [20:0] s3_hours_ff;
   logic [5:0]  s3_mins_lo_ff;
   logic [5:0]  s3_second_ff;

   assign hour_prod = 64'(s2_mins_ff[26:2]) * 64'(DIV15_MAGIC);
   assign hours_in  = hour_prod[55:35];
   assign second_in = s2_secs_lo_ff + {s2_mins_ff[3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_range_ff   <= s2_range_ff;
         s3_hours_ff   <= hours_in;
         s3_mins_lo_ff <= s2_mins_ff[5:0];
         s3_second_ff  <= second_in;
      end
   end

   // stage 4: whole days = hours/24 = (hours>>3)/3, minute mod 64
   logic [63:0] day_prod;
   logic [15:0] days_in;
   logic [5:0]  minute_in;
   logic        s4_valid_ff;
   logic        s4_range_ff;
   logic [15:0] s4_days_ff;
   logic [4:0]  s4_hours_lo_ff;
   logic [5:0]  s4_minute_ff;
   logic [5:0]  s4_second_ff;

   assign day_prod  = 64'(s3_hours_ff[20:3]) * 64'(DIV3_MAGIC);
   assign days_in   = day_prod[48:33];
   assign minute_in = s3_mins_lo_ff + {s3_hours_ff[3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_range_ff    <= s3_range_ff;
         s4_days_ff     <= days_in;
         s4_hours_lo_ff <= s3_hours_ff[4:0];
         s4_minute_ff   <= minute_in;
         s4_second_ff   <= s3_second_ff;
      end
   end

   // hour = hours - 24*days taken mod 32
   epsc_tod_type tod;

   assign tod.hour   = s4_hours_lo_ff + {s4_days_ff[1:0], 3'b000};
   assign tod.minute = s4_minute_ff;
   assign tod.second = s4_second_ff;

   // stages 5 to 9: year, month and day
   epsc_date_walk u_date_walk (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .day_valid    (s4_valid_ff),
      .day_count    (s4_days_ff),
      .day_in_range (s4_range_ff),
      .day_tod      (tod),
      .result_valid (out_valid),
      .result       (out_result)
   );

   // result ports
   assign rsp_valid            = out_valid;
   assign rsp_year_offset      = out_result.year;
   assign rsp_month_number     = out_result.month;
   assign rsp_day_of_month     = out_result.day;
   assign rsp_hour_of_day      = out_result.tod.hour;
   assign rsp_minute_of_hour   = out_result.tod.minute;
   assign rsp_second_of_minute = out_result.tod.second;
   assign rsp_in_range         = out_result.in_range;

endmodule

`default_nettype wire
